[src/pslrt_pkg.sv]
// Shared types and constants for the sequence loss and reorder tracker.
package pslrt_pkg;

    localparam int RING_DEPTH_DEF = 128;
    localparam logic [14:0] WINDOW_RESET = 15'd255;

    typedef enum logic [1:0] {
        OP_DATA    = 2'd0,
        OP_PARITY  = 2'd1,
        OP_RECOVER = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] seq;
        logic [15:0] size;
        logic [31:0] arrival_time;
    } t_in_word;

    typedef struct packed {
        logic [31:0] data_bytes;
        logic [31:0] data_packets;
        logic [31:0] parity_bytes;
        logic [31:0] parity_packets;
        logic [31:0] recovered_count;
        logic [31:0] lost_count;
        logic [31:0] disorder_count;
        logic [31:0] duplicate_count;
        logic [31:0] gap_sum;
        logic [15:0] highest_seq;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FILL,
        ST_SEARCH,
        ST_CHECK,
        ST_CLEAR,
        ST_DONE
    } t_state;

endpackage

[src/pslrt_ring.sv]
// Loss ring memory with a valid bit per entry and registered read data.
module pslrt_ring #(
    parameter int DEPTH = pslrt_pkg::RING_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic          i_clr,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata,
    output logic          o_rvalid
);
    import pslrt_pkg::*;

    logic [15:0]      mem [DEPTH];
    logic [DEPTH-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            o_rvalid <= 1'b0;
        end else begin
            o_rvalid <= r_valid[i_raddr] && !(i_we && i_waddr == i_raddr);
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_clr) begin
                r_valid[i_raddr] <= 1'b0;
            end
        end
    end

endmodule

[src/packet_seq_loss_reorder_tracker_core.sv]
// Top level of the packet sequence loss and reorder tracker.
// Usage:
//   Drive i_word and pulse start while busy is low; the word is taken at
//   that edge. Exactly one result word appears on o_word with o_valid high
//   for one cycle; the receiver cannot hold it off.
//   i_cfg_we with i_cfg_wdata writes the reorder window; the user must do so while idle, the block does not enforce it.
// Handling per word:
//   parity, recovered, unused and first data words: evaluate, then show.
//   data word moving forward by d: min(d-1, RING_DEPTH) ring writes,
//   one ring write per cycle.
//   late or equal data word: reads up to RING_DEPTH entries, a read and
//   a check per entry through the single read port, plus a clear on a hit.
//   busy stays high until the result is shown; the next word may start in
//   the cycle after o_valid.
// Reset:
//   clears all counters, the highest number and every ring valid bit at
//   once; the window returns to 255.
module packet_seq_loss_reorder_tracker_core #(
    parameter int RING_DEPTH = pslrt_pkg::RING_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pslrt_pkg::t_in_word   i_word,
    input  logic                  i_cfg_we,
    input  logic [14:0]           i_cfg_wdata,
    output logic                  o_valid,
    output pslrt_pkg::t_out_word  o_word
);
    import pslrt_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);
    localparam logic [16:0] DEPTH17 = 17'(RING_DEPTH);

    t_state r_state, n_state;
    t_in_word r_in;
    logic [14:0] r_window;
    logic r_seen;
    logic [15:0] r_top;
    logic [31:0] r_prev, r_gap;
    logic [31:0] r_dbytes, r_dpkts, r_pbytes, r_ppkts, r_recov, r_lost, r_dis, r_dup;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [15:0] r_fill, n_fill;
    logic [16:0] r_left, n_left;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_chk;

    logic we, clr;
    logic [AW-1:0] waddr, raddr;
    logic [15:0] rdata;
    logic rvalid;

    logic signed [17:0] diff, dadj;
    logic [16:0] mag;
    logic [16:0] nskip;

    pslrt_ring #(.DEPTH(RING_DEPTH), .AW(AW)) u_ring (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_we(we), .i_waddr(waddr), .i_wdata(r_fill),
        .i_clr(clr), .i_raddr(raddr),
        .o_rdata(rdata), .o_rvalid(rvalid)
    );

    always_comb begin
        diff = 18'(signed'({2'b00, r_in.seq})) - 18'(signed'({2'b00, r_top}));
        mag = diff[17] ? 17'(-diff) : 17'(diff);
        dadj = diff;
        if (mag > {2'b00, r_window}) begin
            dadj = diff[17] ? diff + 18'sd65536 : diff - 18'sd65536;
        end
        nskip = 17'(dadj - 18'sd1);
    end

    always_comb begin
        n_state = r_state;
        n_ptr = r_ptr;
        n_fill = r_fill;
        n_left = r_left;
        n_idx = r_idx;
        we = 1'b0;
        clr = 1'b0;
        waddr = n_ptr;
        raddr = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = ST_DONE;
                if (t_op'(r_in.operation) == OP_DATA && r_seen) begin
                    if (!dadj[17] && dadj != 18'sd0) begin
                        n_left = (nskip > DEPTH17) ? DEPTH17 : nskip;
                        n_fill = r_top + 16'(nskip - n_left) + 16'd1;
                        n_state = ST_FILL;
                    end else begin
                        n_idx = '0;
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_FILL: begin
                if (r_left == 17'd0) begin
                    n_state = ST_DONE;
                end else begin
                    n_ptr = (r_ptr == LAST) ? '0 : r_ptr + 1'b1;
                    waddr = n_ptr;
                    we = 1'b1;
                    n_fill = r_fill + 16'd1;
                    n_left = r_left - 17'd1;
                end
            end
            ST_SEARCH: begin
                raddr = r_idx;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (rvalid && rdata == r_in.seq) begin
                    n_state = ST_CLEAR;
                end else if (r_idx == LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = ST_SEARCH;
                end
            end
            ST_CLEAR: begin
                raddr = r_chk;
                clr = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) r_in <= i_word;
        r_fill <= n_fill;
        r_left <= n_left;
        r_idx <= n_idx;
        if (r_state == ST_SEARCH) r_chk <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_window <= WINDOW_RESET;
            r_seen <= 1'b0;
            r_top <= '0;
            r_prev <= '0;
            r_gap <= '0;
            r_ptr <= '0;
            {r_dbytes, r_dpkts, r_pbytes, r_ppkts} <= '0;
            {r_recov, r_lost, r_dis, r_dup} <= '0;
        end else begin
            r_state <= n_state;
            r_ptr <= n_ptr;
            if (i_cfg_we) r_window <= i_cfg_wdata;
            if (r_state == ST_EVAL) begin
                unique case (t_op'(r_in.operation))
                    OP_DATA: begin
                        r_dpkts <= r_dpkts + 32'd1;
                        r_dbytes <= r_dbytes + {16'd0, r_in.size};
                        r_prev <= r_in.arrival_time;
                        if (!r_seen) begin
                            r_seen <= 1'b1;
                            r_top <= r_in.seq;
                        end else begin
                            r_gap <= r_gap + (r_in.arrival_time - r_prev);
                            if (!dadj[17] && dadj != 18'sd0) begin
                                r_lost <= r_lost + {15'd0, nskip};
                                r_top <= r_in.seq;
                            end else begin
                                r_dis <= r_dis + 32'd1;
                            end
                        end
                    end
                    OP_PARITY: begin
                        r_ppkts <= r_ppkts + 32'd1;
                        r_pbytes <= r_pbytes + {16'd0, r_in.size};
                    end
                    OP_RECOVER: r_recov <= r_recov + 32'd1;
                    OP_NONE: ;
                    default: ;
                endcase
            end
            if (r_state == ST_CLEAR) r_lost <= r_lost - 32'd1;
            if (r_state == ST_CHECK && n_state == ST_DONE) r_dup <= r_dup + 32'd1;
        end
    end

    assign busy = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_DONE);
    assign o_word = '{data_bytes: r_dbytes, data_packets: r_dpkts,
                      parity_bytes: r_pbytes, parity_packets: r_ppkts,
                      recovered_count: r_recov, lost_count: r_lost,
                      disorder_count: r_dis, duplicate_count: r_dup,
                      gap_sum: r_gap, highest_seq: r_top};

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy) else $error("result not followed by idle");
    a_start_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == ST_EVAL)) else $error("start lost");
    a_clr_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr |=> (r_state == ST_DONE)) else $error("clear not final");
    a_no_we_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> !we) else $error("write during search");

endmodule

[tb/sv/testbench.sv]
// Self-checking bench for the sequence loss and reorder tracker core.
module testbench;
    import pslrt_pkg::*;

    localparam int DEPTH = RING_DEPTH_DEF;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_word    i_word;
    logic        i_cfg_we;
    logic [14:0] i_cfg_wdata;
    logic        o_valid;
    t_out_word   o_word;

    packet_seq_loss_reorder_tracker_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_word      (i_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_word      (o_word)
    );

    // tracker state mirror
    logic [14:0] window;
    logic        got_first;
    logic [15:0] top;
    logic [31:0] last_arrival;
    logic [31:0] gap_acc;
    logic [15:0] lost_num [DEPTH];
    logic        lost_vld [DEPTH];
    int          wr_ptr;
    logic [31:0] n_dbytes, n_dpkts, n_pbytes, n_ppkts, n_recov, n_lost, n_disorder, n_dup;

    t_out_word   pending_stats [$];
    int          errors;
    bit          idle_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200000000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    function automatic void clear_model();
        window = WINDOW_RESET;
        got_first = 1'b0;
        top = '0;
        last_arrival = '0;
        gap_acc = '0;
        for (int k = 0; k < DEPTH; k++) begin
            lost_num[k] = '0;
            lost_vld[k] = 1'b0;
        end
        wr_ptr = 0;
        {n_dbytes, n_dpkts, n_pbytes, n_ppkts, n_recov, n_lost, n_disorder, n_dup} = '0;
    endfunction

    function automatic t_out_word track_word(input t_in_word w);
        t_out_word r;
        int        d;
        int        mag;
        int        n;
        int        k;
        bit        hit;
        case (t_op'(w.operation))
            OP_DATA: begin
                n_dpkts++;
                n_dbytes += w.size;
                if (!got_first) begin
                    got_first = 1'b1;
                    top = w.seq;
                    last_arrival = w.arrival_time;
                end else begin
                    gap_acc += w.arrival_time - last_arrival;
                    last_arrival = w.arrival_time;
                    d = int'(w.seq) - int'(top);
                    mag = d < 0 ? -d : d;
                    if (mag > int'(window)) d = d > 0 ? d - 65536 : d + 65536;
                    if (d > 0) begin
                        n = d - 1;
                        n_lost += n;
                        for (k = (n > DEPTH ? n - DEPTH : 0); k < n; k++) begin
                            wr_ptr = (wr_ptr + 1) % DEPTH;
                            lost_num[wr_ptr] = 16'(top + 1 + k);
                            lost_vld[wr_ptr] = 1'b1;
                        end
                        top = w.seq;
                    end else begin
                        hit = 1'b0;
                        for (k = 0; k < DEPTH && !hit; k++) begin
                            if (lost_vld[k] && lost_num[k] == w.seq) begin
                                lost_vld[k] = 1'b0;
                                n_lost--;
                                hit = 1'b1;
                            end
                        end
                        if (!hit) n_dup++;
                        n_disorder++;
                    end
                end
            end
            OP_PARITY: begin
                n_ppkts++;
                n_pbytes += w.size;
            end
            OP_RECOVER: n_recov++;
            default: ;
        endcase
        r.data_bytes = n_dbytes;
        r.data_packets = n_dpkts;
        r.parity_bytes = n_pbytes;
        r.parity_packets = n_ppkts;
        r.recovered_count = n_recov;
        r.lost_count = n_lost;
        r.disorder_count = n_disorder;
        r.duplicate_count = n_dup;
        r.gap_sum = gap_acc;
        r.highest_seq = top;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid) begin
            if (pending_stats.size() == 0) begin
                report("unexpected result word", 32'd1, 32'd0);
            end else begin
                want = pending_stats.pop_front();
                if (o_word.data_bytes !== want.data_bytes)
                    report("data_bytes", o_word.data_bytes, want.data_bytes);
                if (o_word.data_packets !== want.data_packets)
                    report("data_packets", o_word.data_packets, want.data_packets);
                if (o_word.parity_bytes !== want.parity_bytes)
                    report("parity_bytes", o_word.parity_bytes, want.parity_bytes);
                if (o_word.parity_packets !== want.parity_packets)
                    report("parity_packets", o_word.parity_packets, want.parity_packets);
                if (o_word.recovered_count !== want.recovered_count)
                    report("recovered_count", o_word.recovered_count, want.recovered_count);
                if (o_word.lost_count !== want.lost_count)
                    report("lost_count", o_word.lost_count, want.lost_count);
                if (o_word.disorder_count !== want.disorder_count)
                    report("disorder_count", o_word.disorder_count, want.disorder_count);
                if (o_word.duplicate_count !== want.duplicate_count)
                    report("duplicate_count", o_word.duplicate_count, want.duplicate_count);
                if (o_word.gap_sum !== want.gap_sum)
                    report("gap_sum", o_word.gap_sum, want.gap_sum);
                if (o_word.highest_seq !== want.highest_seq)
                    report("highest_seq", 32'(o_word.highest_seq), 32'(want.highest_seq));
            end
        end
    end

    // send one word; start is lowered only when no word follows directly
    task automatic send_word(input logic [1:0] op, input logic [15:0] sq,
                             input logic [15:0] sz, input logic [31:0] at);
        t_in_word w;
        w.operation = op;
        w.seq = sq;
        w.size = sz;
        w.arrival_time = at;
        if (idle_on) begin
            while ($urandom_range(99) < 36) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_word <= w;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_stats.push_back(track_word(w));
        @(negedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_stats.size() != 0 && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (2 * DEPTH + 10) @(negedge i_clk);
    endtask

    task automatic set_window(input logic [14:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        window = v;
    endtask

    logic [15:0] cur_seq;
    logic [31:0] cur_time;

    task automatic data_word(input logic [15:0] sq);
        cur_time += $urandom_range(2000);
        send_word(OP_DATA, sq, 16'($urandom), cur_time);
    endtask

    task automatic test_directed();
        send_word(OP_PARITY, 16'hffff, 16'hffff, 32'hffffffff);
        send_word(OP_RECOVER, 16'h0, 16'h0, 32'h0);
        send_word(OP_NONE, 16'h1234, 16'h55aa, 32'h1);
        send_word(OP_DATA, 16'hfff0, 16'hffff, 32'hfffffff0);
        send_word(OP_DATA, 16'hfff5, 16'h0, 32'h00000010);
        send_word(OP_DATA, 16'hfff2, 16'h1, 32'h20);
        send_word(OP_DATA, 16'hfff2, 16'h1, 32'h30);
        send_word(OP_DATA, 16'hfff5, 16'h1, 32'h30);
        send_word(OP_DATA, 16'h0003, 16'h2, 32'h40);
        send_word(OP_DATA, 16'hffff, 16'h2, 32'h50);
        send_word(OP_DATA, 16'h0000, 16'h2, 32'h60);
        send_word(OP_DATA, 16'h00c8, 16'h3, 32'h70);
        send_word(OP_DATA, 16'h0010, 16'h3, 32'h80);
        send_word(OP_DATA, 16'h0001, 16'h3, 32'h90);
        send_word(OP_DATA, 16'h8000, 16'h3, 32'ha0);
        send_word(OP_DATA, 16'h00c8, 16'h3, 32'hb0);
        cur_seq = 16'h00c8;
        cur_time = 32'hb0;
    endtask

    task automatic test_window_extremes();
        set_window(15'd1);
        data_word(cur_seq + 16'd1);
        data_word(cur_seq + 16'd3);
        data_word(cur_seq - 16'd1);
        data_word(cur_seq + 16'd2);
        cur_seq += 16'd2;
        set_window(15'h7fff);
        data_word(cur_seq + 16'h7fff);
        data_word(cur_seq + 16'h4000);
        data_word(cur_seq - 16'h100);
        cur_seq += 16'h7fff;
        set_window(15'd40);
    endtask

    task automatic random_burst(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                cur_seq += 16'($urandom_range(1, 12));
                data_word(cur_seq);
            end else if (r < 65) begin
                data_word(cur_seq - 16'($urandom_range(0, 20)));
            end else if (r < 70) begin
                cur_seq += 16'($urandom_range(100, 300));
                data_word(cur_seq);
            end else if (r < 75) begin
                send_word(OP_DATA, 16'($urandom), 16'($urandom), $urandom);
            end else if (r < 87) begin
                send_word(OP_PARITY, 16'($urandom), 16'($urandom), $urandom);
            end else if (r < 97) begin
                send_word(OP_RECOVER, 16'($urandom), 16'($urandom), $urandom);
            end else begin
                send_word(OP_NONE, 16'($urandom), 16'($urandom), $urandom);
            end
        end
    endtask

    task automatic test_random();
        idle_on = 1'b1;
        random_burst(500);
        set_window(15'd255);
        idle_on = 1'b0;
        random_burst(400);
        idle_on = 1'b1;
        drain();
        set_window(15'd1000);
        random_burst(450);
        set_window(15'd8);
        random_burst(450);
    endtask

    initial begin
        errors = 0;
        idle_on = 1'b1;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_word = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        clear_model();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_window_extremes();
        test_random();
        drain();
        if (errors == 0 && pending_stats.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
